@@ design/hash_table_linear_probe_defines.svh @@
// ============================================================================
// Hash table assertion macros
// Shared concurrent assertion forms for the hash table block.
// ============================================================================
`ifndef HASH_TABLE_LINEAR_PROBE_DEFINES_SVH
`define HASH_TABLE_LINEAR_PROBE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HTLP_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hash table assertion failed");

// Next-cycle implication, disabled during reset.
`define HTLP_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hash table assertion failed");

`endif

@@ design/htlp_pkg.sv @@
// ============================================================================
// Hash table package
// Types, codes and the control program of the linear probing hash table.
// ============================================================================
package htlp_pkg;

    localparam int TABLE_SIZE_DEF = 16;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int MARK_W   = 2;
    localparam int KEY_BIT_W = $clog2(KEY_W);

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
    localparam logic [MARK_W-1:0] MARK_USED    = 2'd1;
    localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

    typedef struct packed {
        logic [MARK_W-1:0]  mark;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef enum logic [2:0] {
        STEP_CLEAR,
        STEP_IDLE,
        STEP_HASH,
        STEP_INIT,
        STEP_PROBE,
        STEP_FINISH
    } step_t;

    typedef enum logic [2:0] {
        ACT_CLEAR,
        ACT_IDLE,
        ACT_HASH,
        ACT_INIT,
        ACT_PROBE,
        ACT_FINISH
    } act_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_WAIT_IN,
        COND_MORE,
        COND_PROBE_MORE,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t on_true;
        step_t on_false;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic cnt_last;
        logic probe_stop;
        logic out_busy;
    } seq_flags_t;

    function automatic ctrl_t program_word(input step_t step);
        ctrl_t word;
        unique case (step)
            STEP_CLEAR:  word = '{ACT_CLEAR,  COND_MORE,       STEP_CLEAR,  STEP_IDLE};
            STEP_IDLE:   word = '{ACT_IDLE,   COND_WAIT_IN,    STEP_IDLE,   STEP_HASH};
            STEP_HASH:   word = '{ACT_HASH,   COND_MORE,       STEP_HASH,   STEP_INIT};
            STEP_INIT:   word = '{ACT_INIT,   COND_ALWAYS,     STEP_PROBE,  STEP_PROBE};
            STEP_PROBE:  word = '{ACT_PROBE,  COND_PROBE_MORE, STEP_PROBE,  STEP_FINISH};
            STEP_FINISH: word = '{ACT_FINISH, COND_OUT_BUSY,   STEP_FINISH, STEP_IDLE};
            default:     word = '{ACT_IDLE,   COND_ALWAYS,     STEP_IDLE,   STEP_IDLE};
        endcase
        return word;
    endfunction

endpackage

@@ design/htlp_ifs.sv @@
// ============================================================================
// Hash table channels
// Request and response channels with valid/ready handshake.
// ============================================================================
interface htlp_req_if;
    logic                         valid;
    logic                         ready;
    logic [htlp_pkg::OP_W-1:0]    op;
    logic [htlp_pkg::KEY_W-1:0]   key;
    logic [htlp_pkg::VALUE_W-1:0] value_in;

    modport source (output valid, output op, output key, output value_in, input ready);
    modport sink (input valid, input op, input key, input value_in, output ready);
endinterface

interface htlp_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [htlp_pkg::STATUS_W-1:0] status;
    logic                          hit;
    logic [htlp_pkg::VALUE_W-1:0]  value_out;

    modport source (output valid, output status, output hit, output value_out, input ready);
    modport sink (input valid, input status, input hit, input value_out, output ready);
endinterface

@@ design/hash_table_linear_probe.sv @@
// ============================================================================
// Linear probing hash table
// Key-value table with open addressing, tombstones and bounded probes.
// ============================================================================
// Each accepted item passes the hash, init, probe and finish steps before the next one
// is accepted, and it probes 1 to TABLE_SIZE slots. The home-slot remainder sums bit
// residues four key bits a cycle, the probe reads one slot per cycle, and a waiting
// result stalls the finish step. After reset a clearing pass marks every slot empty
// and no item is accepted during it.
`include "hash_table_linear_probe_defines.svh"

module hash_table_linear_probe #(
    parameter int TABLE_SIZE = htlp_pkg::TABLE_SIZE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    htlp_req_if.sink    req,
    htlp_rsp_if.source  rsp
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int CNT_W = (IDX_W > htlp_pkg::KEY_BIT_W) ? IDX_W : htlp_pkg::KEY_BIT_W;
    localparam int DIGIT_W     = 4;
    localparam int DIGIT_BIT_W = $clog2(DIGIT_W);
    localparam int HASH_STEPS  = htlp_pkg::KEY_W / DIGIT_W;
    localparam int DIGIT_SEL_W = $clog2(HASH_STEPS);
    localparam int SUM_W       = IDX_W + 3;

    function automatic int pow2_mod(input int bit_pos);
        int w;
        w = 1;
        for (int i = 0; i < bit_pos; i++)
        begin
            w = w * 2;
            if (w >= TABLE_SIZE)
            begin
                w = w - TABLE_SIZE;
            end
        end
        return w;
    endfunction

    htlp_pkg::ctrl_t      ctrl;
    htlp_pkg::seq_flags_t flags;

    logic [htlp_pkg::OP_W-1:0]     op_reg;
    logic [htlp_pkg::KEY_W-1:0]    key_reg;
    logic [htlp_pkg::VALUE_W-1:0]  val_reg;
    logic [IDX_W-1:0]              rem_reg;
    logic [IDX_W-1:0]              rem_next;
    logic [CNT_W-1:0]              cnt_reg;
    logic [IDX_W-1:0]              idx_reg;
    logic [IDX_W-1:0]              idx_inc;
    logic [IDX_W-1:0]              end_slot_reg;
    logic [IDX_W-1:0]              del_slot_reg;
    logic                          del_valid_reg;
    logic                          found_reg;
    logic                          empty_reg;
    logic [htlp_pkg::VALUE_W-1:0]  hit_val_reg;

    logic                          out_valid_reg;
    logic [htlp_pkg::STATUS_W-1:0] status_reg;
    logic [htlp_pkg::STATUS_W-1:0] status_next;
    logic                          hit_reg;
    logic                          hit_next;
    logic [htlp_pkg::VALUE_W-1:0]  vout_reg;
    logic [htlp_pkg::VALUE_W-1:0]  vout_next;

    logic                          accept;
    logic                          out_free;
    logic                          cnt_last;
    logic [IDX_W-1:0]              bit_weight [htlp_pkg::KEY_W];
    logic [DIGIT_SEL_W-1:0]        digit_sel;
    logic [SUM_W-1:0]              hash_sum;
    logic                          is_used;
    logic                          is_match;
    logic                          is_del;
    logic                          is_empty;
    logic                          free_ok;
    logic [IDX_W-1:0]              free_slot;

    logic                          ram_we;
    logic [IDX_W-1:0]              ram_waddr;
    htlp_pkg::slot_t               ram_wdata;
    logic [IDX_W-1:0]              ram_raddr;
    logic [htlp_pkg::SLOT_W-1:0]   ram_rdata;
    htlp_pkg::slot_t               rd_slot;

    htlp_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    htlp_ram #(
        .WIDTH (htlp_pkg::SLOT_W),
        .DEPTH (TABLE_SIZE)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready = (ctrl.act == htlp_pkg::ACT_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.hit       = hit_reg;
    assign rsp.value_out = vout_reg;

    always_comb
    begin
        if (ctrl.act == htlp_pkg::ACT_HASH)
        begin
            cnt_last = (cnt_reg == CNT_W'(HASH_STEPS - 1));
        end
        else
        begin
            cnt_last = (cnt_reg == CNT_W'(TABLE_SIZE - 1));
        end
    end

    for (genvar j = 0; j < htlp_pkg::KEY_W; j++)
    begin : g_weight
        localparam int WEIGHT = pow2_mod(j);
        assign bit_weight[j] = IDX_W'(WEIGHT);
    end

    // Four key bits per cycle are added as residues of their powers of two.
    always_comb
    begin
        digit_sel = cnt_reg[DIGIT_SEL_W-1:0];
        hash_sum  = SUM_W'(rem_reg);
        for (int k = 0; k < DIGIT_W; k++)
        begin
            if (key_reg[{digit_sel, DIGIT_BIT_W'(k)}])
            begin
                hash_sum = hash_sum + SUM_W'(bit_weight[{digit_sel, DIGIT_BIT_W'(k)}]);
            end
        end
        if (hash_sum >= SUM_W'(4 * TABLE_SIZE))
        begin
            hash_sum = hash_sum - SUM_W'(4 * TABLE_SIZE);
        end
        if (hash_sum >= SUM_W'(2 * TABLE_SIZE))
        begin
            hash_sum = hash_sum - SUM_W'(2 * TABLE_SIZE);
        end
        if (hash_sum >= SUM_W'(TABLE_SIZE))
        begin
            hash_sum = hash_sum - SUM_W'(TABLE_SIZE);
        end
        rem_next = hash_sum[IDX_W-1:0];
    end

    assign idx_inc = (idx_reg == IDX_W'(TABLE_SIZE - 1)) ? '0 : idx_reg + 1'b1;

    always_comb
    begin
        rd_slot  = htlp_pkg::slot_t'(ram_rdata);
        is_used  = (rd_slot.mark == htlp_pkg::MARK_USED);
        is_del   = (rd_slot.mark == htlp_pkg::MARK_DELETED);
        is_empty = !is_used && !is_del;
        is_match = is_used && (rd_slot.key == key_reg);
    end

    always_comb
    begin
        flags.in_valid   = req.valid;
        flags.cnt_last   = cnt_last;
        flags.probe_stop = is_match || is_empty || cnt_last;
        flags.out_busy   = !out_free;
    end

    always_comb
    begin
        if (ctrl.act == htlp_pkg::ACT_INIT)
        begin
            ram_raddr = rem_reg;
        end
        else
        begin
            ram_raddr = idx_inc;
        end
    end

    assign free_ok   = del_valid_reg || empty_reg;
    assign free_slot = del_valid_reg ? del_slot_reg : end_slot_reg;

    always_comb
    begin
        ram_we          = 1'b0;
        ram_waddr       = end_slot_reg;
        ram_wdata.mark  = htlp_pkg::MARK_USED;
        ram_wdata.key   = key_reg;
        ram_wdata.value = val_reg;
        status_next     = htlp_pkg::ST_NOT_FOUND;
        hit_next        = 1'b0;
        vout_next       = '0;
        if (ctrl.act == htlp_pkg::ACT_CLEAR)
        begin
            ram_we          = 1'b1;
            ram_waddr       = cnt_reg[IDX_W-1:0];
            ram_wdata.mark  = htlp_pkg::MARK_EMPTY;
            ram_wdata.key   = '0;
            ram_wdata.value = '0;
        end
        else if (ctrl.act == htlp_pkg::ACT_FINISH)
        begin
            unique case (op_reg)
                htlp_pkg::OP_INSERT:
                begin
                    if (found_reg)
                    begin
                        ram_we      = out_free;
                        status_next = htlp_pkg::ST_DONE;
                        hit_next    = 1'b1;
                    end
                    else if (free_ok)
                    begin
                        ram_we      = out_free;
                        ram_waddr   = free_slot;
                        status_next = htlp_pkg::ST_DONE;
                    end
                    else
                    begin
                        status_next = htlp_pkg::ST_FULL;
                    end
                end
                htlp_pkg::OP_LOOKUP:
                begin
                    if (found_reg)
                    begin
                        status_next = htlp_pkg::ST_DONE;
                        hit_next    = 1'b1;
                        vout_next   = hit_val_reg;
                    end
                end
                htlp_pkg::OP_REMOVE:
                begin
                    if (found_reg)
                    begin
                        ram_we         = out_free;
                        ram_wdata.mark = htlp_pkg::MARK_DELETED;
                        status_next    = htlp_pkg::ST_DONE;
                        hit_next       = 1'b1;
                    end
                end
                default:
                begin
                    status_next = htlp_pkg::ST_NOT_FOUND;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            empty_reg     <= 1'b0;
            del_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (ctrl.act)
                htlp_pkg::ACT_CLEAR:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                htlp_pkg::ACT_IDLE:
                begin
                    if (accept)
                    begin
                        cnt_reg <= '0;
                    end
                end
                htlp_pkg::ACT_HASH:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                htlp_pkg::ACT_INIT:
                begin
                    cnt_reg       <= '0;
                    found_reg     <= 1'b0;
                    empty_reg     <= 1'b0;
                    del_valid_reg <= 1'b0;
                end
                htlp_pkg::ACT_PROBE:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (is_match)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (is_empty)
                    begin
                        empty_reg <= 1'b1;
                    end
                    if (is_del && !del_valid_reg)
                    begin
                        del_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    cnt_reg <= cnt_reg;
                end
            endcase

            if ((ctrl.act == htlp_pkg::ACT_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= req.op;
            key_reg <= req.key;
            val_reg <= req.value_in;
            rem_reg <= '0;
        end
        else if (ctrl.act == htlp_pkg::ACT_HASH)
        begin
            rem_reg <= rem_next;
        end

        if (ctrl.act == htlp_pkg::ACT_INIT)
        begin
            idx_reg <= rem_reg;
        end
        else if (ctrl.act == htlp_pkg::ACT_PROBE)
        begin
            idx_reg      <= idx_inc;
            end_slot_reg <= idx_reg;
            hit_val_reg  <= rd_slot.value;
            if (is_del && !del_valid_reg)
            begin
                del_slot_reg <= idx_reg;
            end
        end

        if ((ctrl.act == htlp_pkg::ACT_FINISH) && out_free)
        begin
            status_reg <= status_next;
            hit_reg    <= hit_next;
            vout_reg   <= vout_next;
        end
    end

    `HTLP_ASSERT_NXT(a_accept_starts_hash, clk, rst_n, accept, ctrl.act == htlp_pkg::ACT_HASH)
    `HTLP_ASSERT_IMP(a_write_steps, clk, rst_n, ram_we, ctrl.act == htlp_pkg::ACT_CLEAR || ctrl.act == htlp_pkg::ACT_FINISH)
    `HTLP_ASSERT_IMP(a_probe_bound, clk, rst_n, ctrl.act == htlp_pkg::ACT_PROBE, cnt_reg <= CNT_W'(TABLE_SIZE - 1))
    `HTLP_ASSERT_NXT(a_finish_gives_result, clk, rst_n, (ctrl.act == htlp_pkg::ACT_FINISH) && out_free, rsp.valid && (ctrl.act == htlp_pkg::ACT_IDLE))

endmodule

@@ design/htlp_ram.sv @@
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module htlp_ram #(
    parameter int WIDTH = htlp_pkg::SLOT_W,
    parameter int DEPTH = htlp_pkg::TABLE_SIZE_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/htlp_seq.sv @@
// ============================================================================
// Hash table sequencer
// Step counter over the control program with conditional branches.
// ============================================================================
module htlp_seq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  htlp_pkg::seq_flags_t   flags,
    output htlp_pkg::ctrl_t        ctrl
);

    htlp_pkg::step_t upc_reg;
    htlp_pkg::step_t upc_next;
    htlp_pkg::ctrl_t word;
    logic            take;

    always_comb
    begin
        word = htlp_pkg::program_word(upc_reg);
        unique case (word.cond)
            htlp_pkg::COND_ALWAYS:     take = 1'b1;
            htlp_pkg::COND_WAIT_IN:    take = !flags.in_valid;
            htlp_pkg::COND_MORE:       take = !flags.cnt_last;
            htlp_pkg::COND_PROBE_MORE: take = !flags.probe_stop;
            htlp_pkg::COND_OUT_BUSY:   take = flags.out_busy;
            default:                   take = 1'b1;
        endcase
        upc_next = take ? word.on_true : word.on_false;
    end

    always_comb
    begin
        ctrl = htlp_pkg::program_word(upc_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= htlp_pkg::STEP_CLEAR;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule
